>>> rtl/core/mtg_pkg.sv
`timescale 1ns / 1ps

package mtg_pkg;

  localparam int WORDS        = 624;
  localparam int IDX_W        = 10;
  localparam int WORD_W       = 32;
  localparam int NUM_W        = 31;
  localparam int TWIST_OFFSET = 397;

  localparam logic [WORD_W-1:0] SEED_MULT = 32'd1812433253;
  localparam logic [WORD_W-1:0] MATRIX_A  = 32'h9908b0df;
  localparam logic [WORD_W-1:0] TEMPER_B  = 32'h9d2c5680;
  localparam logic [WORD_W-1:0] TEMPER_C  = 32'hefc60000;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WORDS - 1);
  localparam logic [IDX_W-1:0] EMPTY    = IDX_W'(WORDS);

  typedef enum logic {
    FUNC_DRAW   = 1'b0,
    FUNC_RESEED = 1'b1
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED_MUL,
    ST_SEED_WR,
    ST_RG_PRE,
    ST_RG_LOAD,
    ST_RG_READ,
    ST_RG_CALC,
    ST_DR_READ,
    ST_DR_OUT
  } state_t;

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

>>> rtl/core/mersenne_twister_generator.sv
`timescale 1ns / 1ps

// MT19937 generator with a 624-word single-write, dual-read state memory.
// A draw (func 0) returns the tempered next word shifted right by one as a
// 31-bit number; when words are left and the output register is free, the
// word is read in ST_DR_READ and registered out from ST_DR_OUT.
// When the store is used up (after reset or a reseed) the draw first twists
// all 624 words through one twist unit, which happens once every 624 draws.
// A reseed (func 1) gives no result: the seed recurrence runs through one
// 32x32 multiplier, alternating a multiply and a write state for each word.
// The input is stalled for the whole of an item; a result waiting in the
// output register does not hold off a reseed. Draw before the first reseed is
// not supported.
module mersenne_twister_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [31:0] seed,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [30:0] number
);

  localparam int IW = mtg_pkg::IDX_W;
  localparam int WW = mtg_pkg::WORD_W;

  mtg_pkg::state_t state, state_next;

  logic [WW-1:0] mem [mtg_pkg::WORDS];
  logic [WW-1:0] rd_a, rd_b;
  logic [WW-1:0] acc;
  logic [WW-1:0] prod;
  logic [IW-1:0] k;
  logic [IW-1:0] idx;

  logic          we;
  logic [IW-1:0] waddr;
  logic [WW-1:0] wdata;
  logic [IW-1:0] raddr_a, raddr_b;

  logic          in_xfer;
  logic          out_free;
  logic [IW:0]   far_sum;
  logic [IW-1:0] far_addr;
  logic [IW-1:0] nxt_addr;
  logic [WW-1:0] mix;
  logic [WW-1:0] twist;
  logic [WW-1:0] seed_word;
  logic [WW-1:0] tempered;

  assign in_stall = (state != mtg_pkg::ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign far_sum  = {1'b0, k} + (IW+1)'(mtg_pkg::TWIST_OFFSET);
  assign far_addr = (far_sum >= (IW+1)'(mtg_pkg::WORDS)) ?
                    IW'(far_sum - (IW+1)'(mtg_pkg::WORDS)) : far_sum[IW-1:0];
  assign nxt_addr = (k == mtg_pkg::LAST_IDX) ? '0 : k + IW'(1);

  // rd_a: following word, rd_b: word TWIST_OFFSET ahead, acc: current word
  assign mix       = {acc[WW-1], rd_a[WW-2:0]};
  assign twist     = rd_b ^ (mix >> 1) ^ (rd_a[0] ? mtg_pkg::MATRIX_A : '0);
  assign seed_word = prod + {{(WW-IW){1'b0}}, k};
  assign tempered  = mtg_pkg::temper(rd_a);

  always_comb begin
    state_next = state;
    case (state)
      mtg_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (func == mtg_pkg::FUNC_RESEED) begin
            state_next = mtg_pkg::ST_SEED_MUL;
          end else if (idx == mtg_pkg::EMPTY) begin
            state_next = mtg_pkg::ST_RG_PRE;
          end else begin
            state_next = mtg_pkg::ST_DR_READ;
          end
        end
      end
      mtg_pkg::ST_SEED_MUL: state_next = mtg_pkg::ST_SEED_WR;
      mtg_pkg::ST_SEED_WR: begin
        state_next = (k == mtg_pkg::LAST_IDX) ? mtg_pkg::ST_IDLE : mtg_pkg::ST_SEED_MUL;
      end
      mtg_pkg::ST_RG_PRE:  state_next = mtg_pkg::ST_RG_LOAD;
      mtg_pkg::ST_RG_LOAD: state_next = mtg_pkg::ST_RG_READ;
      mtg_pkg::ST_RG_READ: state_next = mtg_pkg::ST_RG_CALC;
      mtg_pkg::ST_RG_CALC: begin
        state_next = (k == mtg_pkg::LAST_IDX) ? mtg_pkg::ST_DR_READ : mtg_pkg::ST_RG_READ;
      end
      mtg_pkg::ST_DR_READ: state_next = mtg_pkg::ST_DR_OUT;
      mtg_pkg::ST_DR_OUT: begin
        if (out_free) begin
          state_next = mtg_pkg::ST_IDLE;
        end
      end
      default: state_next = mtg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    we      = 1'b0;
    waddr   = k;
    wdata   = twist;
    raddr_a = '0;
    raddr_b = '0;
    case (state)
      mtg_pkg::ST_IDLE: begin
        if (in_xfer && func == mtg_pkg::FUNC_RESEED) begin
          we    = 1'b1;
          waddr = '0;
          wdata = seed;
        end
      end
      mtg_pkg::ST_SEED_WR: begin
        we    = 1'b1;
        wdata = seed_word;
      end
      mtg_pkg::ST_RG_READ: begin
        raddr_a = nxt_addr;
        raddr_b = far_addr;
      end
      mtg_pkg::ST_RG_CALC: begin
        we = 1'b1;
      end
      mtg_pkg::ST_DR_READ,
      mtg_pkg::ST_DR_OUT: begin
        raddr_a = idx;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a <= mem[raddr_a];
    rd_b <= mem[raddr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mtg_pkg::ST_IDLE;
      idx       <= mtg_pkg::EMPTY;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == mtg_pkg::ST_DR_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        mtg_pkg::ST_IDLE: begin
          if (in_xfer) begin
            if (func == mtg_pkg::FUNC_RESEED) begin
              acc <= seed;
              k   <= IW'(1);
              idx <= mtg_pkg::EMPTY;
            end else begin
              k <= '0;
            end
          end
        end
        mtg_pkg::ST_SEED_MUL: begin
          prod <= mtg_pkg::SEED_MULT * (acc ^ (acc >> 30));
        end
        mtg_pkg::ST_SEED_WR: begin
          acc <= seed_word;
          k   <= k + IW'(1);
        end
        mtg_pkg::ST_RG_LOAD: begin
          acc <= rd_a;
        end
        mtg_pkg::ST_RG_CALC: begin
          acc <= rd_a;
          k   <= k + IW'(1);
          if (k == mtg_pkg::LAST_IDX) begin
            idx <= '0;
          end
        end
        mtg_pkg::ST_DR_OUT: begin
          if (out_free) begin
            number <= tempered[WW-1:1];
            idx    <= idx + IW'(1);
          end
        end
        default: begin
          k <= k;
        end
      endcase
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= mtg_pkg::EMPTY)
    else $error("read index past end of store");

  a_regen_start: assert property (@(posedge clk) disable iff (rst)
    in_xfer && func == mtg_pkg::FUNC_DRAW && idx == mtg_pkg::EMPTY
      |=> state == mtg_pkg::ST_RG_PRE)
    else $error("draw on empty store did not regenerate");

  a_regen_end: assert property (@(posedge clk) disable iff (rst)
    state == mtg_pkg::ST_RG_CALC && k == mtg_pkg::LAST_IDX
      |=> state == mtg_pkg::ST_DR_READ && idx == '0)
    else $error("regeneration did not rewind read index");

  a_write_addr: assert property (@(posedge clk) disable iff (rst)
    we |-> waddr <= mtg_pkg::LAST_IDX)
    else $error("write beyond store");

endmodule
